[design/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Implication after a fixed number of cycles, disabled during reset.
`define ASSERT_DELAY(lbl, clk, rst, a, n, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (c)) \
    else $error("assertion failed");

`endif

[design/tag_pkg.sv]
// Shared widths, sideband type and latency of the gradient setup pipeline.
// Depends on nothing.
package tag_pkg;
  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int MAG_W      = NUM_W - 1;
  localparam int FRAC_SHIFT = 12;
  localparam int DVS_W      = MAG_W + 1;
  localparam int DVD_W      = MAG_W + FRAC_SHIFT + 2;
  localparam int STEP_W     = 32;
  localparam int FRONT_LAT  = 4;
  localparam int LATENCY    = FRONT_LAT + DVD_W + 1;

  // Control that travels alongside each triangle.
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic degen;
  } tag_side_t;
endpackage

[design/tag_front.sv]
// Front end: vertex differences, cross products, numerators and divider operands.
// Depends on tag_pkg.
module tag_front import tag_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, va, vb, vc,
  output tag_side_t                 side,
  output logic        [DVS_W-1:0]   divisor,
  output logic        [DVD_W-1:0]   dividend_x,
  output logic        [DVD_W-1:0]   dividend_y
);
  logic                     v1, v2, v3;
  logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb, dva, dvb;
  logic signed [PROD_W-1:0] p_den0, p_den1, p_nx0, p_nx1, p_ny0, p_ny1;
  logic signed [NUM_W-1:0]  den, nx, nyn;
  logic        [MAG_W-1:0]  ad, anx, any;

  // Valid bits through the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: differences against the third vertex.
  always_ff @(posedge clk) begin
    dxa <= DIFF_W'(ax) - DIFF_W'(cx);
    dya <= DIFF_W'(ay) - DIFF_W'(cy);
    dxb <= DIFF_W'(bx) - DIFF_W'(cx);
    dyb <= DIFF_W'(by) - DIFF_W'(cy);
    dva <= DIFF_W'(va) - DIFF_W'(vc);
    dvb <= DIFF_W'(vb) - DIFF_W'(vc);
  end

  // Stage 2: six products.
  always_ff @(posedge clk) begin
    p_den0 <= dxb * dya;
    p_den1 <= dxa * dyb;
    p_nx0  <= dvb * dya;
    p_nx1  <= dva * dyb;
    p_ny0  <= dva * dxb;
    p_ny1  <= dvb * dxa;
  end

  // Stage 3: area and the two numerators; y numerator is already negated.
  always_ff @(posedge clk) begin
    den <= NUM_W'(p_den0) - NUM_W'(p_den1);
    nx  <= NUM_W'(p_nx0) - NUM_W'(p_nx1);
    nyn <= NUM_W'(p_ny0) - NUM_W'(p_ny1);
  end

  // Magnitudes for the unsigned divider.
  always_comb begin
    ad  = den[NUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
    anx = nx[NUM_W-1]  ? MAG_W'(-nx)  : MAG_W'(nx);
    any = nyn[NUM_W-1] ? MAG_W'(-nyn) : MAG_W'(nyn);
  end

  // Stage 4: rounding bias folded into the dividend, divisor is twice the area.
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= v3;
    end
    side.degen <= (den == '0);
    side.neg_x <= nx[NUM_W-1] ^ den[NUM_W-1];
    side.neg_y <= nyn[NUM_W-1] ^ den[NUM_W-1];
    divisor    <= (den == '0) ? DVS_W'(2) : {ad, 1'b0};
    dividend_x <= {anx, {(FRAC_SHIFT + 1){1'b0}}} + DVD_W'(ad);
    dividend_y <= {any, {(FRAC_SHIFT + 1){1'b0}}} + DVD_W'(ad);
  end
endmodule

[design/tag_div_stage.sv]
// One restoring-division step: one quotient bit per register stage.
// Depends on tag_pkg.
module tag_div_stage import tag_pkg::*; (
  input  logic             clk,
  input  logic [DVS_W-1:0] dvs_in,
  input  logic [DVS_W-1:0] rem_in,
  input  logic [DVD_W-1:0] dvd_in,
  input  logic [DVD_W-1:0] quo_in,
  output logic [DVS_W-1:0] dvs_out,
  output logic [DVS_W-1:0] rem_out,
  output logic [DVD_W-1:0] dvd_out,
  output logic [DVD_W-1:0] quo_out
);
  logic [DVS_W:0] trial;
  logic           fits;

  // Shift the next dividend bit in and try the subtraction.
  always_comb begin
    trial = {rem_in, dvd_in[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs_in});
  end

  always_ff @(posedge clk) begin
    dvs_out <= dvs_in;
    rem_out <= fits ? DVS_W'(trial - {1'b0, dvs_in}) : DVS_W'(trial);
    dvd_out <= {dvd_in[DVD_W-2:0], 1'b0};
    quo_out <= {quo_in[DVD_W-2:0], fits};
  end
endmodule

[design/tag_divider.sv]
// Two-lane pipelined divider with sideband control; each lane carries its own copy of the divisor.
// Depends on tag_pkg and tag_div_stage.
module tag_divider import tag_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tag_side_t        side_in,
  input  logic [DVS_W-1:0] divisor,
  input  logic [DVD_W-1:0] dividend_x,
  input  logic [DVD_W-1:0] dividend_y,
  output tag_side_t        side_out,
  output logic [DVD_W-1:0] quo_x,
  output logic [DVD_W-1:0] quo_y
);
  logic [DVS_W-1:0] dvs   [DVD_W+1];
  logic [DVS_W-1:0] dvs_y [DVD_W+1];
  logic [DVS_W-1:0] rx  [DVD_W+1];
  logic [DVS_W-1:0] ry  [DVD_W+1];
  logic [DVD_W-1:0] dx  [DVD_W+1];
  logic [DVD_W-1:0] dy  [DVD_W+1];
  logic [DVD_W-1:0] qx  [DVD_W+1];
  logic [DVD_W-1:0] qy  [DVD_W+1];
  tag_side_t        side [DVD_W+1];

  assign dvs[0]   = divisor;
  assign dvs_y[0] = divisor;
  assign rx[0]    = '0;
  assign ry[0]    = '0;
  assign dx[0]    = dividend_x;
  assign dy[0]    = dividend_y;
  assign qx[0]    = '0;
  assign qy[0]    = '0;
  assign side[0]  = side_in;

  // Sideband travels in step with the quotient bits.
  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else begin
        side[k+1].valid <= side[k].valid;
      end
      side[k+1].neg_x <= side[k].neg_x;
      side[k+1].neg_y <= side[k].neg_y;
      side[k+1].degen <= side[k].degen;
    end

    tag_div_stage u_x (
      .clk(clk), .dvs_in(dvs[k]), .rem_in(rx[k]), .dvd_in(dx[k]), .quo_in(qx[k]),
      .dvs_out(dvs[k+1]), .rem_out(rx[k+1]), .dvd_out(dx[k+1]), .quo_out(qx[k+1])
    );
    tag_div_stage u_y (
      .clk(clk), .dvs_in(dvs_y[k]), .rem_in(ry[k]), .dvd_in(dy[k]), .quo_in(qy[k]),
      .dvs_out(dvs_y[k+1]), .rem_out(ry[k+1]), .dvd_out(dy[k+1]), .quo_out(qy[k+1])
    );
  end

  assign side_out = side[DVD_W];
  assign quo_x    = qx[DVD_W];
  assign quo_y    = qy[DVD_W];
endmodule

[design/tag_post.sv]
// Output stage: sign, saturation to 32 bits and the zero-area override.
// Depends on tag_pkg.
module tag_post import tag_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tag_side_t                side,
  input  logic        [DVD_W-1:0]  quo_x,
  input  logic        [DVD_W-1:0]  quo_y,
  output logic                     done,
  output logic signed [STEP_W-1:0] step_x,
  output logic signed [STEP_W-1:0] step_y,
  output logic                     degen
);
  localparam logic [DVD_W-1:0] POS_MAX = DVD_W'({1'b0, {(STEP_W - 1){1'b1}}});
  localparam logic [DVD_W-1:0] NEG_MAX = DVD_W'({1'b1, {(STEP_W - 1){1'b0}}});

  function automatic logic [STEP_W-1:0] saturate(logic [DVD_W-1:0] q, logic neg);
    logic [DVD_W-1:0] m;
    begin
      if (neg) begin
        m = (q > NEG_MAX) ? NEG_MAX : q;
        saturate = STEP_W'(-m);
      end else begin
        m = (q > POS_MAX) ? POS_MAX : q;
        saturate = STEP_W'(m);
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid;
    end
    degen  <= side.degen;
    step_x <= side.degen ? '0 : saturate(quo_x, side.neg_x);
    step_y <= side.degen ? '0 : saturate(quo_y, side.neg_y);
  end
endmodule

[design/triangle_attribute_gradient_unit.sv]
// Triangle attribute gradient setup: Q20.12 steps per x and y from three vertices.
// The start beat reaches the done strobe through 4 setup stages, 49 divider stages
// and one output register; one triangle is taken every cycle.
// busy stays low, since the 49-stage restoring divider takes a new beat each cycle.
// Synchronous reset clears all valid bits; results in flight are dropped.
`include "assert_macros.svh"
module triangle_attribute_gradient_unit import tag_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COORD_W-1:0] first_x,
  input  logic signed [COORD_W-1:0] first_y,
  input  logic signed [COORD_W-1:0] second_x,
  input  logic signed [COORD_W-1:0] second_y,
  input  logic signed [COORD_W-1:0] third_x,
  input  logic signed [COORD_W-1:0] third_y,
  input  logic signed [COORD_W-1:0] first_value,
  input  logic signed [COORD_W-1:0] second_value,
  input  logic signed [COORD_W-1:0] third_value,
  output logic                     done,
  output logic signed [STEP_W-1:0] step_along_x,
  output logic signed [STEP_W-1:0] step_along_y,
  output logic                     degenerate
);
  tag_side_t        f_side, d_side;
  logic [DVS_W-1:0] divisor;
  logic [DVD_W-1:0] dvd_x, dvd_y, q_x, q_y;

  assign busy = 1'b0;

  tag_front u_front (
    .clk(clk), .rst(rst), .in_valid(start & ~busy),
    .ax(first_x), .ay(first_y), .bx(second_x), .by(second_y),
    .cx(third_x), .cy(third_y),
    .va(first_value), .vb(second_value), .vc(third_value),
    .side(f_side), .divisor(divisor), .dividend_x(dvd_x), .dividend_y(dvd_y)
  );

  tag_divider u_div (
    .clk(clk), .rst(rst), .side_in(f_side), .divisor(divisor),
    .dividend_x(dvd_x), .dividend_y(dvd_y),
    .side_out(d_side), .quo_x(q_x), .quo_y(q_y)
  );

  tag_post u_post (
    .clk(clk), .rst(rst), .side(d_side), .quo_x(q_x), .quo_y(q_y),
    .done(done), .step_x(step_along_x), .step_y(step_along_y), .degen(degenerate)
  );

  // Every accepted beat produces its strobe a fixed latency later.
  `ASSERT_DELAY(a_latency, clk, rst, start, 54, done)
  // A zero-area result carries zero steps.
  `ASSERT_IMPLY(a_degen_zero, clk, rst, done && degenerate,
                step_along_x == '0 && step_along_y == '0)
  // A done strobe always follows a live beat leaving the divider.
  `ASSERT_IMPLY(a_side_valid, clk, rst, done, $past(d_side.valid))
endmodule

[dv/tb_triangle_attribute_gradient_unit.sv]
// Self-checking testbench for triangle_attribute_gradient_unit: drives triangles,
// predicts Q20.12 gradient steps and compares every done beat in order.
// Depends on tag_pkg and the RTL of the unit.
module tb_triangle_attribute_gradient_unit import tag_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_W-1:0] triangle_t [9];

  typedef struct {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic                     degen;
  } gradient_t;

  // Keeps the gradients still owed by the unit and compares them on arrival.
  class gradient_scoreboard;
    gradient_t owed[$];
    int mismatches = 0;
    int matched = 0;
    int degenerate_seen = 0;
    int saturated_seen = 0;

    // Rounded (ties away from zero), saturated num * 2^12 / den.
    function logic [STEP_W-1:0] scaled_quotient(longint num, longint den);
      bit neg;
      longint unsigned mag_num, mag_den, q;
      neg = (num < 0) != (den < 0);
      mag_num = (num < 0) ? -num : num;
      mag_den = (den < 0) ? -den : den;
      q = ((mag_num << (FRAC_SHIFT + 1)) + mag_den) / (mag_den << 1);
      if (q == 0) return '0;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -q[STEP_W-1:0];
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[STEP_W-1:0];
    endfunction

    function gradient_t gradient_of(triangle_t t);
      gradient_t g;
      longint dxa, dya, dxb, dyb, dva, dvb, den, nx, ny;
      dxa = longint'(t[0]) - longint'(t[4]);
      dya = longint'(t[1]) - longint'(t[5]);
      dxb = longint'(t[2]) - longint'(t[4]);
      dyb = longint'(t[3]) - longint'(t[5]);
      dva = longint'(t[6]) - longint'(t[8]);
      dvb = longint'(t[7]) - longint'(t[8]);
      den = dxb * dya - dxa * dyb;
      nx = dvb * dya - dva * dyb;
      ny = dvb * dxa - dva * dxb;
      if (den == 0) begin
        g.step_x = '0;
        g.step_y = '0;
        g.degen = 1'b1;
      end else begin
        g.step_x = scaled_quotient(nx, den);
        g.step_y = scaled_quotient(-ny, den);
        g.degen = 1'b0;
      end
      return g;
    endfunction

    function void note_triangle(triangle_t t);
      owed.push_back(gradient_of(t));
    endfunction

    function void check_gradient(logic signed [STEP_W-1:0] sx, logic signed [STEP_W-1:0] sy,
                                 logic dg);
      gradient_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected done beat: x=%0d y=%0d degen=%b", sx, sy, dg);
        return;
      end
      e = owed.pop_front();
      if (sx !== e.step_x || sy !== e.step_y || dg !== e.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: gradient exp x=%0d y=%0d degen=%b, got x=%0d y=%0d degen=%b",
                   e.step_x, e.step_y, e.degen, sx, sy, dg);
      end else begin
        matched++;
        if (e.degen) degenerate_seen++;
        if (e.step_x == 32'sh7FFF_FFFF || e.step_x == -32'sh8000_0000 ||
            e.step_y == 32'sh7FFF_FFFF || e.step_y == -32'sh8000_0000)
          saturated_seen++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic signed [COORD_W-1:0] third_x = '0, third_y = '0;
  logic signed [COORD_W-1:0] first_value = '0, second_value = '0, third_value = '0;
  logic done;
  logic signed [STEP_W-1:0] step_along_x, step_along_y;
  logic degenerate;

  gradient_scoreboard board = new();
  int idle_cycles = 0;
  int burst_left = 0;

  triangle_attribute_gradient_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note accepted triangles and check every done beat at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_triangle('{first_x, first_y, second_x, second_y, third_x, third_y,
                              first_value, second_value, third_value});
      if (done)
        board.check_gradient(step_along_x, step_along_y, degenerate);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // A stuck pipeline ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("triangle_attribute_gradient_unit regression: fail");
      $finish;
    end
  end

  // Present one triangle and hold it until taken, then maybe leave a gap.
  task automatic send_triangle(triangle_t t);
    int gap;
    {first_x, first_y, second_x, second_y, third_x, third_y} <=
      {t[0], t[1], t[2], t[3], t[4], t[5]};
    {first_value, second_value, third_value} <= {t[6], t[7], t[8]};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] near(int base, int spread);
    return COORD_W'(base + $urandom_range(0, 2 * spread) - spread);
  endfunction

  // Random triangle: wide noise, compact, collinear or sliver shapes.
  function automatic triangle_t random_triangle();
    triangle_t t;
    int kind, ax, ay, dx, dy, k;
    for (int i = 0; i < 9; i++) t[i] = COORD_W'($urandom);
    kind = $urandom_range(0, 99);
    ax = $urandom_range(0, 32000) - 16000;
    ay = $urandom_range(0, 32000) - 16000;
    if (kind < 40) begin
      for (int i = 2; i < 6; i += 2) begin
        t[i] = near(ax, 2000);
        t[i+1] = near(ay, 2000);
      end
      t[0] = COORD_W'(ax);
      t[1] = COORD_W'(ay);
    end else if (kind < 55) begin
      dx = $urandom_range(0, 4000) - 2000;
      dy = $urandom_range(0, 4000) - 2000;
      k = $urandom_range(0, 6) - 3;
      t[0] = COORD_W'(ax);        t[1] = COORD_W'(ay);
      t[2] = COORD_W'(ax + dx);   t[3] = COORD_W'(ay + dy);
      t[4] = COORD_W'(ax + k*dx); t[5] = COORD_W'(ay + k*dy);
    end else if (kind < 70) begin
      t[0] = COORD_W'(ax);     t[1] = COORD_W'(ay);
      t[2] = near(ax, 2);      t[3] = near(ay, 2);
      t[4] = near(ax, 2);      t[5] = near(ay, 2);
    end
    return t;
  endfunction

  initial begin
    triangle_t directed[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes, zero area, both windings and saturation in both directions.
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{-32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768, 0});
    directed.push_back('{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767});
    directed.push_back('{32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767});
    directed.push_back('{0, 0, 16, 0, 0, 16, 0, 256, 512});
    directed.push_back('{0, 0, 0, 16, 16, 0, 0, 256, 512});
    directed.push_back('{0, 0, 1, 0, 0, 1, -32768, 32767, 0});
    directed.push_back('{0, 0, 1, 0, 0, 1, 32767, -32768, 0});
    directed.push_back('{0, 0, 0, 1, 1, 0, 32767, -32768, -32768});
    directed.push_back('{100, 100, 200, 200, 300, 300, 5, 6, 7});
    directed.push_back('{5, 5, 5, 5, 9, 9, 1, 2, 3});
    directed.push_back('{0, 0, 3, 0, 0, 2, 1, 0, 0});
    directed.push_back('{0, 0, 3, 0, 0, 2, -1, 0, 0});
    directed.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    directed.push_back('{32767, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768});
    foreach (directed[i]) send_triangle(directed[i]);
    drain_pipeline();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_triangle(random_triangle());
      if (n == RANDOM_ITEMS / 2) drain_pipeline();
    end
    drain_pipeline();
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d triangles checked, %0d with zero area, %0d with a saturated step",
             board.matched, board.degenerate_seen, board.saturated_seen);
    $display("mismatches %0d, results still owed %0d", board.mismatches, board.owed.size());
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("triangle_attribute_gradient_unit regression: pass");
    end else begin
      $display("triangle_attribute_gradient_unit regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/tag_pkg.sv
design/tag_front.sv
design/tag_div_stage.sv
design/tag_divider.sv
design/tag_post.sv
design/triangle_attribute_gradient_unit.sv
dv/tb_triangle_attribute_gradient_unit.sv
